[sv/b64le_pkg.sv]
// ----------------------------------------------------------------------------
// b64le_pkg
// Shared types, constants and the base64 alphabet for the line encoder.
// ----------------------------------------------------------------------------
package b64le_pkg;

  localparam logic [7:0] PAD_CHAR     = 8'h3D;  // '='
  localparam logic [7:0] NEWLINE_CHAR = 8'h0A;
  localparam logic [5:0] GPL_RESET    = 6'd19;

  // One complete group handed from the front to the back
  typedef struct packed {
    logic [23:0] data;    // {b0, b1, b2}, zero-filled
    logic [1:0]  nbytes;  // 1..3 real bytes
    logic        wrap;    // line is full after this group
    logic        last;    // final group of the message
  } grp_t;

  function automatic logic [7:0] b64_char(input logic [5:0] idx);
    logic [7:0] i8;
    i8 = {2'b00, idx};
    if (idx < 6'd26)      b64_char = 8'h41 + i8;
    else if (idx < 6'd52) b64_char = 8'h61 + i8 - 8'd26;
    else if (idx < 6'd62) b64_char = 8'h30 + i8 - 8'd52;
    else if (idx == 6'd62) b64_char = 8'h2B;
    else                  b64_char = 8'h2F;
  endfunction

endpackage

[sv/b64le_byte_if.sv]
// ----------------------------------------------------------------------------
// b64le_byte_if
// Valid/ready channel carrying raw message bytes.
// ----------------------------------------------------------------------------
interface b64le_byte_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;
  logic       end_of_message;

  modport source (output valid, output data_byte, output end_of_message, input ready);
  modport sink   (input valid, input data_byte, input end_of_message, output ready);
endinterface

[sv/b64le_char_if.sv]
// ----------------------------------------------------------------------------
// b64le_char_if
// Valid/ready channel carrying encoded characters.
// ----------------------------------------------------------------------------
interface b64le_char_if;
  logic       valid;
  logic       ready;
  logic [7:0] out_char;
  logic       last_of_run;

  modport source (output valid, output out_char, output last_of_run, input ready);
  modport sink   (input valid, input out_char, input last_of_run, output ready);
endinterface

[sv/b64le_front.sv]
// ----------------------------------------------------------------------------
// b64le_front
// Gathers bytes into groups, tracks line position and queues group records.
// ----------------------------------------------------------------------------
module b64le_front (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              cfg_wr_en,
  input  logic [5:0]        cfg_wr_data,
  input  logic              byte_valid,
  input  logic [7:0]        byte_data,
  input  logic              byte_eom,
  output logic              byte_ready,
  input  logic              q_full,
  output logic              q_push,
  output b64le_pkg::grp_t   q_grp
);
  import b64le_pkg::*;

  logic [5:0] gpl_r;
  logic [7:0] held0_r, held0_nxt;
  logic [7:0] held1_r, held1_nxt;
  logic [1:0] cnt_r, cnt_nxt;
  logic [5:0] gol_r, gol_nxt;
  logic       acc;
  logic       hold;
  logic       wrap;

  assign byte_ready = !q_full;
  assign acc        = byte_valid && byte_ready;
  // cnt_r never reaches 3; bit 1 alone means two bytes held
  assign hold       = !byte_eom && !cnt_r[1];
  assign wrap       = ({1'b0, gol_r} + 7'd1) >= {1'b0, gpl_r};

  always_comb begin
    held0_nxt = held0_r;
    held1_nxt = held1_r;
    cnt_nxt   = cnt_r;
    gol_nxt   = gol_r;
    q_push    = 1'b0;

    q_grp.nbytes = cnt_r + 2'd1;
    q_grp.wrap   = wrap;
    q_grp.last   = byte_eom;
    if (cnt_r[1])
      q_grp.data = {held0_r, held1_r, byte_data};
    else if (cnt_r[0])
      q_grp.data = {held0_r, byte_data, 8'h00};
    else
      q_grp.data = {byte_data, 16'h0000};

    if (acc) begin
      if (hold) begin
        if (cnt_r[0]) held1_nxt = byte_data;
        else          held0_nxt = byte_data;
        cnt_nxt = cnt_r + 2'd1;
      end else begin
        q_push  = 1'b1;
        cnt_nxt = 2'd0;
        gol_nxt = (wrap || byte_eom) ? 6'd0 : gol_r + 6'd1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      gpl_r <= GPL_RESET;
      cnt_r <= 2'd0;
      gol_r <= 6'd0;
    end else begin
      if (cfg_wr_en) gpl_r <= cfg_wr_data;
      cnt_r <= cnt_nxt;
      gol_r <= gol_nxt;
    end
  end

  always_ff @(posedge clk) begin
    held0_r <= held0_nxt;
    held1_r <= held1_nxt;
  end

endmodule

[sv/b64le_fifo.sv]
// ----------------------------------------------------------------------------
// b64le_fifo
// Short queue of group records between the front and the back.
// ----------------------------------------------------------------------------
module b64le_fifo #(
  parameter int DEPTH = 2
) (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            push,
  input  b64le_pkg::grp_t wr_grp,
  input  logic            pop,
  output b64le_pkg::grp_t rd_grp,
  output logic            full,
  output logic            empty
);
  import b64le_pkg::*;

  localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);
  localparam logic [PW-1:0] LAST_IDX = PW'(DEPTH - 1);
  localparam logic [CW-1:0] DEPTH_C  = CW'(DEPTH);

  grp_t          slots_r [DEPTH];
  logic [PW-1:0] wp_r, rp_r;
  logic [CW-1:0] count_r;
  logic          do_push, do_pop;

  assign full    = (count_r == DEPTH_C);
  assign empty   = (count_r == '0);
  assign do_push = push && !full;
  assign do_pop  = pop && !empty;
  assign rd_grp  = slots_r[rp_r];

  always_ff @(posedge clk) begin
    if (do_push) slots_r[wp_r] <= wr_grp;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r    <= '0;
      rp_r    <= '0;
      count_r <= '0;
    end else begin
      if (do_push) wp_r <= (wp_r == LAST_IDX) ? '0 : wp_r + PW'(1);
      if (do_pop)  rp_r <= (rp_r == LAST_IDX) ? '0 : rp_r + PW'(1);
      if (do_push && !do_pop)      count_r <= count_r + CW'(1);
      else if (do_pop && !do_push) count_r <= count_r - CW'(1);
    end
  end

endmodule

[sv/b64le_back.sv]
// ----------------------------------------------------------------------------
// b64le_back
// Walks the head group record and emits one character per cycle into the
// output register while a group is queued and the output is not stalled.
// ----------------------------------------------------------------------------
module b64le_back (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            q_empty,
  input  b64le_pkg::grp_t q_grp,
  output logic            q_pop,
  output logic            out_valid,
  output logic [7:0]      out_char,
  output logic            out_last,
  input  logic            out_ready
);
  import b64le_pkg::*;

  logic [2:0] step_r, step_nxt;
  logic       valid_r, valid_nxt;
  logic [7:0] char_r, char_nxt;
  logic       last_r, last_nxt;
  logic       emit;
  logic       final_step;
  logic [2:0] end_step;
  logic [5:0] sextet;
  logic [7:0] ch;

  assign end_step   = 3'd3 + {2'b00, q_grp.wrap} + {2'b00, q_grp.last};
  assign emit       = !q_empty && (!valid_r || out_ready);
  assign final_step = (step_r == end_step);
  assign q_pop      = emit && final_step;

  always_comb begin
    case (step_r)
      3'd0:    sextet = q_grp.data[23:18];
      3'd1:    sextet = q_grp.data[17:12];
      3'd2:    sextet = q_grp.data[11:6];
      default: sextet = q_grp.data[5:0];
    endcase
  end

  always_comb begin
    case (step_r)
      3'd0, 3'd1: ch = b64_char(sextet);
      3'd2:       ch = (q_grp.nbytes >= 2'd2) ? b64_char(sextet) : PAD_CHAR;
      3'd3:       ch = (q_grp.nbytes == 2'd3) ? b64_char(sextet) : PAD_CHAR;
      default:    ch = NEWLINE_CHAR;  // wrap and/or terminating newline
    endcase
  end

  always_comb begin
    step_nxt  = step_r;
    valid_nxt = valid_r;
    char_nxt  = char_r;
    last_nxt  = last_r;
    if (emit) begin
      valid_nxt = 1'b1;
      char_nxt  = ch;
      last_nxt  = final_step;
      step_nxt  = final_step ? 3'd0 : step_r + 3'd1;
    end else if (out_ready) begin
      valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      step_r  <= 3'd0;
      valid_r <= 1'b0;
    end else begin
      step_r  <= step_nxt;
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    char_r <= char_nxt;
    last_r <= last_nxt;
  end

  assign out_valid = valid_r;
  assign out_char  = char_r;
  assign out_last  = last_r;

endmodule

[sv/base64_line_encoder_top.sv]
// ----------------------------------------------------------------------------
// base64_line_encoder_top
// Streaming base64 encoder with line wrapping.
// ----------------------------------------------------------------------------
// in_bus takes one raw byte per transaction; end_of_message marks the final
// byte. out_bus gives one character per transaction: alphabet, '=' pad or
// newline; last_of_run flags the final character of each group of input bytes.
// Each group of three bytes (or a short final group) yields four characters,
// a newline after groups_per_line groups, and one more newline at the end of
// the message. cfg_wr_en/cfg_wr_data load groups_per_line (reset 19).
// The group record is written into the queue when the byte that completes
// the group is taken; its first character then goes into the output register.
// Throughput: bytes are taken one per cycle while the group queue has room;
// the back end sends one character per cycle while a group is queued and
// out_bus does not stall; a group yields 4 to 6 characters.
// Reset clears the held-byte count, line position, queue and output valid, and
// loads groups_per_line with 19. When out_bus stalls, the output register
// holds; the queue (QUEUE_DEPTH groups) absorbs input before in_bus.ready
// drops.
// ----------------------------------------------------------------------------
module base64_line_encoder_top #(
  parameter int QUEUE_DEPTH = 2
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              cfg_wr_en,
  input  logic [5:0]        cfg_wr_data,
  b64le_byte_if.sink        in_bus,
  b64le_char_if.source      out_bus
);
  import b64le_pkg::*;

  grp_t push_grp;
  grp_t head_grp;
  logic q_push, q_pop, q_full, q_empty;

  b64le_front u_front (
    .clk         (clk),
    .rst_n       (rst_n),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data),
    .byte_valid  (in_bus.valid),
    .byte_data   (in_bus.data_byte),
    .byte_eom    (in_bus.end_of_message),
    .byte_ready  (in_bus.ready),
    .q_full      (q_full),
    .q_push      (q_push),
    .q_grp       (push_grp)
  );

  b64le_fifo #(.DEPTH(QUEUE_DEPTH)) u_fifo (
    .clk    (clk),
    .rst_n  (rst_n),
    .push   (q_push),
    .wr_grp (push_grp),
    .pop    (q_pop),
    .rd_grp (head_grp),
    .full   (q_full),
    .empty  (q_empty)
  );

  b64le_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .q_empty   (q_empty),
    .q_grp     (head_grp),
    .q_pop     (q_pop),
    .out_valid (out_bus.valid),
    .out_char  (out_bus.out_char),
    .out_last  (out_bus.last_of_run),
    .out_ready (out_bus.ready)
  );

  // queue status is consistent
  a_q_status: assert property (@(posedge clk) disable iff (!rst_n)
    !(q_full && q_empty))
    else $error("queue reports full and empty");

  // no group record is dropped at a full queue
  a_no_drop: assert property (@(posedge clk) disable iff (!rst_n)
    q_push |-> !q_full)
    else $error("group pushed into full queue");

  // a pop only happens on a queue-to-output move that ends a run
  a_pop_last: assert property (@(posedge clk) disable iff (!rst_n)
    q_pop |=> (out_bus.valid && out_bus.last_of_run))
    else $error("group retired without last_of_run");

endmodule
